### sv/cac_pkg.sv
// Shared types, constants and stage indexes for the circle/box contact test.
package cac_pkg;

  localparam int COORD_FRAC_BITS = 8;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;
  localparam int NSQ = 31;
  localparam int NDV = 16;
  localparam int ST_MUL = 0;
  localparam int ST_SUM = 1;
  localparam int ST_SQ0 = 2;
  localparam int ST_POST = ST_SQ0 + NSQ;
  localparam int ST_DV0 = ST_POST + 1;
  localparam int NST = ST_DV0 + NDV;

  localparam logic signed [15:0] NORM_ONE = 16'sd16384;
  localparam logic [24:0] PEN_MAX = 25'h1FFFFFF;
  localparam logic SHAPE_CIRCLE = 1'b0;
  localparam logic SHAPE_RECT = 1'b1;

  typedef struct packed {
    logic              shape_a;
    logic signed [23:0] pos_a_x;
    logic signed [23:0] pos_a_y;
    logic [21:0]       extent_a_x;
    logic [21:0]       extent_a_y;
    logic              shape_b;
    logic signed [23:0] pos_b_x;
    logic signed [23:0] pos_b_y;
    logic [21:0]       extent_b_x;
    logic [21:0]       extent_b_y;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [24:0]       penetration;
  } out_item_t;

  // Classified item: round contact work or a finished box-box result.
  typedef struct packed {
    logic              round;
    logic              neg;
    logic signed [25:0] vx;
    logic signed [25:0] vy;
    logic [22:0]       rad;
    logic              bhit;
    logic signed [15:0] bnx;
    logic signed [15:0] bny;
    logic [24:0]       bpen;
  } q_item_t;

  typedef struct packed {
    q_item_t     item;
    logic [50:0] sqx;
    logic [50:0] sqy;
    logic [45:0] rr;
    logic        rhit;
    logic        zero;
    logic [61:0] rem;
    logic [61:0] res;
    logic [31:0] len;
    logic [24:0] pen;
    logic [47:0] dxr;
    logic [47:0] dyr;
    logic [15:0] qx;
    logic [15:0] qy;
  } pipe_t;

endpackage

### sv/cac_in_if.sv
// Input channel: one body pair per transfer.
interface cac_in_if import cac_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/cac_out_if.sv
// Output channel: one contact result per transfer.
interface cac_out_if import cac_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/circle_aabb_contact_test.sv
// Top level of the 2D circle / axis-aligned box contact test.
//
//  channel | dir | payload                                   | transfer when
//  in_i    | in  | shapes, centres, extents of bodies A and B | valid && ready
//  out_o   | out | hit, normal_x/y (Q.14), penetration (Q.8) | valid && ready
//
// One pair enters per cycle and one result leaves per cycle, sustained while
// out_o.ready is high. An input pair is written into the queue, then passes
// through the 50 back-end stages (multiply, sum, 31 root digits, length and
// depth, 16 quotient bits, one per stage), then into the output register.
// Reset clears the queue pointers and all stage valid bits; no clearing pass.
// An output stall freezes the whole back end; the 4-entry queue keeps taking
// pairs until full, then in_i.ready drops.
module circle_aabb_contact_test import cac_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cac_in_if.sink    in_i,
  cac_out_if.source out_o
);

  logic    push, pop, q_full, q_empty;
  q_item_t f_item, q_item;

  // classify and resolve box-box up front
  cac_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (f_item)
  );

  // decouples front acceptance from back-end stalls
  cac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (pop),
    .item_o  (q_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // root, divide and result assembly
  cac_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .item_i    (q_item),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

### sv/cac_front.sv
// Front end: accepts pairs, resolves box-box, reduces circle cases to a vector.
module cac_front import cac_pkg::*; (
  cac_in_if.sink  in_i,
  input  logic    q_full_i,
  output logic    push_o,
  output q_item_t item_o
);

  logic signed [26:0] ax, ay, bx, by, ex, ey, fx, fy;
  logic signed [26:0] a_l, a_r, a_t, a_b, b_l, b_r, b_t, b_b;
  logic signed [26:0] o_l, o_r, o_t, o_b, m;
  logic signed [26:0] cx, cy, px, py, hw, hh, lo_x, hi_x, lo_y, hi_y, qx, qy, dx, dy;
  logic [21:0]        crad;
  logic               rhit;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  always_comb begin
    ax = 27'(in_i.data.pos_a_x);
    ay = 27'(in_i.data.pos_a_y);
    bx = 27'(in_i.data.pos_b_x);
    by = 27'(in_i.data.pos_b_y);
    ex = signed'({5'b0, in_i.data.extent_a_x});
    ey = signed'({5'b0, in_i.data.extent_a_y});
    fx = signed'({5'b0, in_i.data.extent_b_x});
    fy = signed'({5'b0, in_i.data.extent_b_y});

    // box-box
    a_l = ax - ex;  a_r = ax + ex;  a_t = ay - ey;  a_b = ay + ey;
    b_l = bx - fx;  b_r = bx + fx;  b_t = by - fy;  b_b = by + fy;
    rhit = !(a_r < b_l || a_l > b_r || a_b < b_t || a_t > b_b);
    o_l = a_r - b_l;  o_r = b_r - a_l;  o_t = a_b - b_t;  o_b = b_b - a_t;

    item_o      = '0;
    item_o.neg  = 1'b0;
    item_o.bhit = rhit;
    // strict compares keep the first minimum: left, right, top, bottom
    m = o_l;
    item_o.bnx = NORM_ONE;
    item_o.bny = '0;
    if (o_r < m) begin
      m = o_r;  item_o.bnx = -NORM_ONE;  item_o.bny = '0;
    end
    if (o_t < m) begin
      m = o_t;  item_o.bnx = '0;  item_o.bny = NORM_ONE;
    end
    if (o_b < m) begin
      m = o_b;  item_o.bnx = '0;  item_o.bny = -NORM_ONE;
    end
    item_o.bpen = (m > signed'({2'b0, PEN_MAX})) ? PEN_MAX : m[24:0];

    // circle against box; swap roles when A is the box
    if (in_i.data.shape_a == SHAPE_CIRCLE) begin
      cx = ax;  cy = ay;  crad = in_i.data.extent_a_x;
      px = bx;  py = by;  hw = fx;  hh = fy;
    end else begin
      cx = bx;  cy = by;  crad = in_i.data.extent_b_x;
      px = ax;  py = ay;  hw = ex;  hh = ey;
    end
    lo_x = px - hw;  hi_x = px + hw;
    lo_y = py - hh;  hi_y = py + hh;
    qx = (cx < lo_x) ? lo_x : ((cx > hi_x) ? hi_x : cx);
    qy = (cy < lo_y) ? lo_y : ((cy > hi_y) ? hi_y : cy);

    if (in_i.data.shape_a == SHAPE_CIRCLE && in_i.data.shape_b == SHAPE_CIRCLE) begin
      dx = bx - ax;
      dy = by - ay;
      item_o.rad = {1'b0, in_i.data.extent_a_x} + {1'b0, in_i.data.extent_b_x};
    end else begin
      dx = qx - cx;
      dy = qy - cy;
      item_o.rad = {1'b0, crad};
    end
    item_o.vx    = dx[25:0];
    item_o.vy    = dy[25:0];
    item_o.round = !(in_i.data.shape_a == SHAPE_RECT && in_i.data.shape_b == SHAPE_RECT);
    item_o.neg   = in_i.data.shape_a == SHAPE_RECT && in_i.data.shape_b == SHAPE_CIRCLE;
  end

endmodule

### sv/cac_queue.sv
// Short register queue between front and back.
module cac_queue import cac_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t item_i,
  input  logic    pop_i,
  output q_item_t item_o,
  output logic    empty_o,
  output logic    full_o
);

  q_item_t        mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == (QAW+1)'(QDEPTH);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QAW+1)'(push_i) - (QAW+1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");

endmodule

### sv/cac_back.sv
// Back end: squares, pipelined square root, pipelined dividers, result assembly.
module cac_back import cac_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  q_item_t item_i,
  output logic    pop_o,
  cac_out_if.source out_o
);

  function automatic pipe_t mul_step(q_item_t it);
    pipe_t p;
    logic signed [51:0] tx, ty;
    p = '0;
    p.item = it;
    tx = 52'(it.vx) * 52'(it.vx);
    ty = 52'(it.vy) * 52'(it.vy);
    p.sqx = tx[50:0];
    p.sqy = ty[50:0];
    p.rr  = 46'(it.rad) * 46'(it.rad);
    return p;
  endfunction

  function automatic pipe_t sum_step(pipe_t s);
    pipe_t p;
    logic [51:0] d2;
    p = s;
    d2 = {1'b0, s.sqx} + {1'b0, s.sqy};
    p.rhit = d2 < {6'b0, s.rr};
    p.zero = d2 == '0;
    p.rem  = {d2[45:0], 16'b0};
    p.res  = '0;
    return p;
  endfunction

  // one digit of the bitwise square root
  function automatic pipe_t sqrt_step(pipe_t s, int k);
    pipe_t p;
    logic [61:0] b, t;
    p = s;
    b = 62'(1) << (2 * (NSQ - 1 - k));
    t = s.res + b;
    if (s.rem >= t) begin
      p.rem = s.rem - t;
      p.res = (s.res >> 1) + b;
    end else begin
      p.res = s.res >> 1;
    end
    return p;
  endfunction

  function automatic pipe_t post_step(pipe_t s);
    pipe_t p;
    logic [32:0] full, lenx, t;
    logic [25:0] mx, my;
    p = s;
    p.len = s.res[31:0] + 32'(s.rem > s.res);
    full = {2'b0, s.item.rad, 8'b0};
    lenx = {1'b0, p.len};
    t = full - lenx + 33'd128;
    p.pen = (full >= lenx) ? t[32:8] : '0;
    if (s.zero) p.pen = {2'b0, s.item.rad};
    mx = s.item.vx[25] ? 26'(-s.item.vx) : 26'(s.item.vx);
    my = s.item.vy[25] ? 26'(-s.item.vy) : 26'(s.item.vy);
    p.dxr = {mx, 22'b0} + {17'b0, p.len[31:1]};
    p.dyr = {my, 22'b0} + {17'b0, p.len[31:1]};
    p.qx = '0;
    p.qy = '0;
    return p;
  endfunction

  // one quotient bit of both normal components
  function automatic pipe_t div_step(pipe_t s, int i);
    pipe_t p;
    logic [47:0] t;
    p = s;
    t = {16'b0, s.len} << i;
    if (s.dxr >= t) begin
      p.dxr = s.dxr - t;
      p.qx[i] = 1'b1;
    end
    if (s.dyr >= t) begin
      p.dyr = s.dyr - t;
      p.qy[i] = 1'b1;
    end
    return p;
  endfunction

  function automatic out_item_t finish(pipe_t s);
    out_item_t o;
    logic [15:0] mx, my;
    logic signed [15:0] nx, ny;
    mx = (s.qx > 16'(NORM_ONE)) ? 16'(NORM_ONE) : s.qx;
    my = (s.qy > 16'(NORM_ONE)) ? 16'(NORM_ONE) : s.qy;
    nx = s.item.vx[25] ? -signed'(mx) : signed'(mx);
    ny = s.item.vy[25] ? -signed'(my) : signed'(my);
    if (s.zero) begin
      nx = NORM_ONE;
      ny = '0;
    end
    if (s.item.neg) begin
      nx = -nx;
      ny = -ny;
    end
    if (s.item.round) begin
      o.hit = s.rhit;
      o.normal_x = nx;
      o.normal_y = ny;
      o.penetration = s.pen;
    end else begin
      o.hit = s.item.bhit;
      o.normal_x = s.item.bnx;
      o.normal_y = s.item.bny;
      o.penetration = s.item.bpen;
    end
    if (!o.hit) begin
      o.normal_x = '0;
      o.normal_y = '0;
      o.penetration = '0;
    end
    return o;
  endfunction

  pipe_t     st_d [NST];
  pipe_t     st_q [NST];
  logic      vld_q [NST];
  logic      adv;
  logic      out_valid_q;
  out_item_t out_q;

  assign adv   = !out_valid_q || out_o.ready;
  assign pop_o = adv && !q_empty_i;

  assign st_d[ST_MUL] = mul_step(item_i);
  assign st_d[ST_SUM] = sum_step(st_q[ST_MUL]);
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    assign st_d[ST_SQ0 + k] = sqrt_step(st_q[ST_SQ0 + k - 1], k);
  end
  assign st_d[ST_POST] = post_step(st_q[ST_POST - 1]);
  for (genvar j = 0; j < NDV; j++) begin : g_div
    assign st_d[ST_DV0 + j] = div_step(st_q[ST_DV0 + j - 1], NDV - 1 - j);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) st_q[k] <= st_d[k];
      out_q <= finish(st_q[NST-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) vld_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= pop_o;
      for (int k = 1; k < NST; k++) vld_q[k] <= vld_q[k-1];
      out_valid_q <= vld_q[NST-1];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.hit |-> out_q.normal_x == '0 && out_q.normal_y == '0
      && out_q.penetration == '0) else $error("miss with nonzero normal or depth");
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.normal_x <= NORM_ONE && out_q.normal_x >= -NORM_ONE
      && out_q.normal_y <= NORM_ONE && out_q.normal_y >= -NORM_ONE)
    else $error("normal out of range");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NST-1] && adv |=> out_valid_q) else $error("result lost at output");

endmodule
